FILE: hw/rtl/lldec_pkg.sv
// Shared types and constants for the learned level switch decoder.
`default_nettype none

package lldec_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned EIDX_W  = 4;
  localparam int unsigned OUT_W   = 4;
  localparam int unsigned FS_W    = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLASSIFY = 2'd0,
    MODE_LEARN    = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLS_FIRST,
    ST_CLS_WALK,
    ST_INS_WALK,
    ST_INS_PUT,
    ST_RM_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/learned_level_switch_decoder_top.sv
// Learned level switch decoder: sorted level table in RAM, walked one entry per cycle.
`default_nettype none

// Keeps up to MAX_LEVELS learned levels, sorted ascending, in a RAM with one
// write and one registered read port. A classify word walks the table one
// entry per cycle and returns the first window holding the sample, stopping
// early on a hit; a learn word shifts larger entries up one per cycle from
// the top; a remove word shifts later entries down one per cycle. The idle
// state takes the word and the done state hands the result to the output
// register. A new word is taken once the previous result sits in the output
// register, even if that result has not been taken yet.
module learned_level_switch_decoder_top #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned FULL_SCALE = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [lldec_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [lldec_pkg::LEVEL_W-1:0] in_level,
  input  wire logic [lldec_pkg::EIDX_W-1:0]  in_entry_index,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [lldec_pkg::OUT_W-1:0]   out_position,
  output      logic [lldec_pkg::OUT_W-1:0]   out_entry_count
);

  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CW1   = CNT_W + 1;
  localparam int unsigned CMP_W = ((CNT_W > lldec_pkg::EIDX_W) ? CNT_W : lldec_pkg::EIDX_W) + 1;
  localparam logic [lldec_pkg::FS_W-1:0] FS_V   = lldec_pkg::FS_W'(FULL_SCALE);
  localparam logic [CNT_W-1:0]           MAX_V  = CNT_W'(MAX_LEVELS);

  lldec_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              walk_r, walk_nxt;
  logic [lldec_pkg::LEVEL_W-1:0] cur_r, cur_nxt;
  logic [lldec_pkg::LEVEL_W-1:0] smp_r, smp_nxt;
  logic [lldec_pkg::OUT_W-1:0]   res_pos_r, res_pos_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [lldec_pkg::OUT_W-1:0]   out_position_r, out_entry_count_r;
  logic                          out_load;

  logic [lldec_pkg::LEVEL_W-1:0] mem [MAX_LEVELS];
  logic [lldec_pkg::LEVEL_W-1:0] rd_data_r;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr, mem_raddr;
  logic [lldec_pkg::LEVEL_W-1:0] mem_wdata;

  logic                          in_acc;
  lldec_pkg::mode_t              mode;
  logic [lldec_pkg::LEVEL_W-1:0] mid;
  logic                          cls_hit, smp_in_range, walk_last;
  logic                          ins_shift, walk_is_one;
  logic [CW1-1:0]                walk_p1, walk_p2, walk_m1;
  logic [CMP_W-1:0]              idx_ext, idx_p1, cnt_ext;
  logic                          idx_bad, idx_is_last, tbl_full, tbl_empty;

  assign in_ready = (state_r == lldec_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign mode     = lldec_pkg::mode_t'(in_mode);

  // midpoint between current entry and the one just read; floor division
  assign mid          = cur_r + ((rd_data_r - cur_r) >> 1);
  assign cls_hit      = (smp_r < mid);
  assign smp_in_range = (lldec_pkg::FS_W'(smp_r) <= FS_V);
  assign walk_p1      = CW1'(walk_r) + CW1'(1);
  assign walk_p2      = CW1'(walk_r) + CW1'(2);
  assign walk_m1      = CW1'(walk_r) - CW1'(1);
  assign walk_last    = (walk_p2 >= CW1'(count_r));
  assign walk_is_one  = (walk_r == CNT_W'(1));
  assign ins_shift    = (rd_data_r > smp_r);

  assign idx_ext     = CMP_W'(in_entry_index);
  assign idx_p1      = idx_ext + CMP_W'(1);
  assign cnt_ext     = CMP_W'(count_r);
  assign idx_bad     = (idx_ext >= cnt_ext);
  assign idx_is_last = (idx_p1 >= cnt_ext);
  assign tbl_full    = (count_r >= MAX_V);
  assign tbl_empty   = (count_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lldec_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority case (mode)
            lldec_pkg::MODE_CLASSIFY:
              state_nxt = tbl_empty ? lldec_pkg::ST_DONE : lldec_pkg::ST_CLS_FIRST;
            lldec_pkg::MODE_LEARN: begin
              if (tbl_full)       state_nxt = lldec_pkg::ST_DONE;
              else if (tbl_empty) state_nxt = lldec_pkg::ST_INS_PUT;
              else                state_nxt = lldec_pkg::ST_INS_WALK;
            end
            lldec_pkg::MODE_REMOVE:
              state_nxt = (idx_bad || idx_is_last) ? lldec_pkg::ST_DONE
                                                   : lldec_pkg::ST_RM_WALK;
            default: state_nxt = lldec_pkg::ST_DONE;
          endcase
        end
      end
      lldec_pkg::ST_CLS_FIRST:
        state_nxt = (count_r == CNT_W'(1)) ? lldec_pkg::ST_DONE : lldec_pkg::ST_CLS_WALK;
      lldec_pkg::ST_CLS_WALK:
        if (cls_hit || walk_last) state_nxt = lldec_pkg::ST_DONE;
      lldec_pkg::ST_INS_WALK: begin
        if (!ins_shift)       state_nxt = lldec_pkg::ST_DONE;
        else if (walk_is_one) state_nxt = lldec_pkg::ST_INS_PUT;
      end
      lldec_pkg::ST_INS_PUT: state_nxt = lldec_pkg::ST_DONE;
      lldec_pkg::ST_RM_WALK:
        if (walk_last) state_nxt = lldec_pkg::ST_DONE;
      lldec_pkg::ST_DONE:
        if (!out_valid_r || out_ready) state_nxt = lldec_pkg::ST_IDLE;
      default: state_nxt = lldec_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_nxt   = count_r;
    walk_nxt    = walk_r;
    cur_nxt     = cur_r;
    smp_nxt     = smp_r;
    res_pos_nxt = res_pos_r;
    mem_we      = 1'b0;
    mem_waddr   = walk_r[IDX_W-1:0];
    mem_wdata   = smp_r;
    mem_raddr   = '0;
    out_load    = 1'b0;
    unique case (state_r)
      lldec_pkg::ST_IDLE: begin
        if (in_acc) begin
          smp_nxt     = in_level;
          res_pos_nxt = '0;
          priority case (mode)
            lldec_pkg::MODE_CLASSIFY: mem_raddr = '0;
            lldec_pkg::MODE_LEARN: begin
              walk_nxt  = count_r;
              mem_raddr = IDX_W'(count_r - CNT_W'(1));
            end
            lldec_pkg::MODE_REMOVE: begin
              walk_nxt  = CNT_W'(in_entry_index);
              mem_raddr = idx_p1[IDX_W-1:0];
              if (!idx_bad && idx_is_last) count_nxt = count_r - CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      lldec_pkg::ST_CLS_FIRST: begin
        cur_nxt   = rd_data_r;
        walk_nxt  = '0;
        mem_raddr = IDX_W'(1);
        if (count_r == CNT_W'(1)) res_pos_nxt = smp_in_range ? lldec_pkg::OUT_W'(1) : '0;
      end
      lldec_pkg::ST_CLS_WALK: begin
        // lower edge already passed on the way here, only the upper edge decides
        if (cls_hit) begin
          res_pos_nxt = lldec_pkg::OUT_W'(walk_p1);
        end else if (walk_last) begin
          res_pos_nxt = smp_in_range ? lldec_pkg::OUT_W'(walk_p2) : '0;
        end else begin
          cur_nxt   = rd_data_r;
          walk_nxt  = walk_p1[CNT_W-1:0];
          mem_raddr = walk_p2[IDX_W-1:0];
        end
      end
      lldec_pkg::ST_INS_WALK: begin
        mem_we = 1'b1;
        if (ins_shift) begin
          mem_wdata = rd_data_r;
          walk_nxt  = walk_m1[CNT_W-1:0];
          mem_raddr = IDX_W'(walk_r - CNT_W'(2));
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      lldec_pkg::ST_INS_PUT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      lldec_pkg::ST_RM_WALK: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        if (walk_last) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          walk_nxt  = walk_p1[CNT_W-1:0];
          mem_raddr = walk_p2[IDX_W-1:0];
        end
      end
      lldec_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lldec_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r    <= walk_nxt;
    cur_r     <= cur_nxt;
    smp_r     <= smp_nxt;
    res_pos_r <= res_pos_nxt;
    if (out_load) begin
      out_position_r    <= res_pos_r;
      out_entry_count_r <= lldec_pkg::OUT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_V)
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |->
      (CW1'(count_r) == CW1'($past(count_r)) + CW1'(1)) ||
      (CW1'(count_r) + CW1'(1) == CW1'($past(count_r))))
    else $error("entry count moved by more than one");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == lldec_pkg::ST_INS_WALK) || (state_r == lldec_pkg::ST_INS_PUT) ||
               (state_r == lldec_pkg::ST_RM_WALK))
    else $error("table write outside learn or remove");

  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> state_r == lldec_pkg::ST_IDLE)
    else $error("result loaded without returning to idle");

endmodule

`default_nettype wire

FILE: dv/lldec_checker.sv
// Checker for the learned level switch decoder: tracks the level table and compares each result word.
module lldec_checker #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned FULL_SCALE = 1023
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [lldec_pkg::MODE_W-1:0]  in_mode,
  input  logic [lldec_pkg::LEVEL_W-1:0] in_level,
  input  logic [lldec_pkg::EIDX_W-1:0]  in_entry_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [lldec_pkg::OUT_W-1:0]   out_position,
  input  logic [lldec_pkg::OUT_W-1:0]   out_entry_count,
  output int unsigned                   err_count,
  output int unsigned                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lldec_pkg::OUT_W-1:0] position;
    logic [lldec_pkg::OUT_W-1:0] entry_count;
  } switch_result_t;

  logic [lldec_pkg::LEVEL_W-1:0] sorted_levels [MAX_LEVELS];
  int unsigned                   level_total;
  switch_result_t                owed_results [$];

  // First window holding the sample, counted from 1; 0 if none.
  function automatic int unsigned position_of(int unsigned sample);
    int lo;
    int hi;
    for (int unsigned i = 0; i < level_total && i < MAX_LEVELS; i++) begin
      if (i == 0) begin
        lo = 0;
      end else begin
        lo = int'(sorted_levels[i-1]) + (int'(sorted_levels[i]) - int'(sorted_levels[i-1])) / 2;
      end
      if (i + 1 >= level_total) begin
        hi = int'(FULL_SCALE);
      end else begin
        hi = int'(sorted_levels[i]) + (int'(sorted_levels[i+1]) - int'(sorted_levels[i])) / 2 - 1;
      end
      if (lo <= int'(sample) && int'(sample) <= hi) return i + 1;
    end
    return 0;
  endfunction

  function automatic void learn_level(logic [lldec_pkg::LEVEL_W-1:0] v);
    int unsigned j;
    if (level_total >= MAX_LEVELS) return;
    j = level_total;
    while (j > 0 && sorted_levels[j-1] > v) begin
      sorted_levels[j] = sorted_levels[j-1];
      j--;
    end
    sorted_levels[j] = v;
    level_total++;
  endfunction

  function automatic void drop_level(int unsigned idx);
    if (idx >= level_total || idx >= MAX_LEVELS) return;
    for (int unsigned j = idx; j + 1 < level_total && j + 1 < MAX_LEVELS; j++) begin
      sorted_levels[j] = sorted_levels[j+1];
    end
    level_total--;
  endfunction

  function automatic switch_result_t decode_word(logic [lldec_pkg::MODE_W-1:0] mode,
                                                 logic [lldec_pkg::LEVEL_W-1:0] level,
                                                 logic [lldec_pkg::EIDX_W-1:0] idx);
    switch_result_t r;
    int unsigned pos;
    pos = 0;
    case (lldec_pkg::mode_t'(mode))
      lldec_pkg::MODE_CLASSIFY: pos = position_of(int'(level));
      lldec_pkg::MODE_LEARN:    learn_level(level);
      lldec_pkg::MODE_REMOVE:   drop_level(int'(idx));
      default:                  pos = 0;
    endcase
    r.position    = pos[lldec_pkg::OUT_W-1:0];
    r.entry_count = level_total[lldec_pkg::OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    switch_result_t want;
    if (!rst_n) begin
      level_total = 0;
      err_count   = 0;
      owed_results.delete();
    end else begin
      // result side first: a word taken at this edge cannot be answered at it
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: position %0d entry_count %0d",
                 out_position, out_entry_count);
          err_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            err_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(decode_word(in_mode, in_level, in_entry_index));
      end
    end
    pending <= owed_results.size();
  end

endmodule

FILE: dv/learned_level_switch_decoder_top_test.sv
// Testbench top for the learned level switch decoder: stimulus, back-pressure and verdict.
module learned_level_switch_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEVELS     = 8;
  localparam int unsigned FULL_SCALE     = 1023;
  localparam int unsigned RANDOM_WORDS   = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned LEVEL_W        = lldec_pkg::LEVEL_W;
  localparam int unsigned EIDX_W         = lldec_pkg::EIDX_W;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [lldec_pkg::MODE_W-1:0]  in_mode        = '0;
  logic [LEVEL_W-1:0]            in_level       = '0;
  logic [EIDX_W-1:0]             in_entry_index = '0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [lldec_pkg::OUT_W-1:0]   out_position;
  logic [lldec_pkg::OUT_W-1:0]   out_entry_count;
  logic                          calm           = 1'b0;  // no idling on either side while set
  int unsigned                   err_count;
  int unsigned                   pending;
  int unsigned                   quiet_cycles   = 0;
  int                            recent_levels [$];

  learned_level_switch_decoder_top #(
    .MAX_LEVELS(MAX_LEVELS),
    .FULL_SCALE(FULL_SCALE)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_level       (in_level),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_entry_count(out_entry_count)
  );

  lldec_checker #(
    .MAX_LEVELS(MAX_LEVELS),
    .FULL_SCALE(FULL_SCALE)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_level       (in_level),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_entry_count(out_entry_count),
    .err_count      (err_count),
    .pending        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // ends the run if neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(lldec_pkg::mode_t mode, logic [LEVEL_W-1:0] level,
                           logic [EIDX_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 28) gap = $urandom_range(12, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_level       <= level;
    in_entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] near_level(int base, int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
    return v[LEVEL_W-1:0];
  endfunction

  task automatic send_random_word(int unsigned n);
    int unsigned        pick;
    bit                 build;
    logic [LEVEL_W-1:0] lvl;
    logic [EIDX_W-1:0]  idx;
    build = ((n / 64) % 2) == 0;
    pick  = $urandom_range(99);
    lvl   = LEVEL_W'($urandom_range(FULL_SCALE));
    idx   = EIDX_W'($urandom_range(15));
    if (pick < (build ? 40 : 12)) begin
      if (recent_levels.size() != 0 && $urandom_range(99) < 20) begin
        // duplicates and near neighbors give empty and tiny windows
        lvl = near_level(recent_levels[$urandom_range(recent_levels.size() - 1)], 2);
      end else if ($urandom_range(99) < 6) begin
        lvl = $urandom_range(1) ? LEVEL_W'(FULL_SCALE) : '0;
      end
      recent_levels.push_back(int'(lvl));
      if (recent_levels.size() > 16) void'(recent_levels.pop_front());
      send_word(lldec_pkg::MODE_LEARN, lvl, idx);
    end else if (pick < (build ? 50 : 45)) begin
      if ($urandom_range(99) < 80) idx = EIDX_W'($urandom_range(MAX_LEVELS - 1));
      send_word(lldec_pkg::MODE_REMOVE, lvl, idx);
    end else if (pick < 96) begin
      if (recent_levels.size() != 0 && $urandom_range(99) < 30) begin
        lvl = near_level(recent_levels[$urandom_range(recent_levels.size() - 1)], 6);
      end
      send_word(lldec_pkg::MODE_CLASSIFY, lvl, idx);
    end else begin
      send_word(lldec_pkg::MODE_NONE, lvl, idx);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table
    send_word(lldec_pkg::MODE_CLASSIFY, '0, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd1023, 4'd15);
    send_word(lldec_pkg::MODE_NONE, '0, '0);
    send_word(lldec_pkg::MODE_REMOVE, 10'd1023, '0);
    // extremes and a duplicate: windows 0..255, 256..511, 512..766, 767..1023
    send_word(lldec_pkg::MODE_LEARN, 10'd1023, '0);
    send_word(lldec_pkg::MODE_LEARN, '0, 4'd15);
    send_word(lldec_pkg::MODE_LEARN, 10'd512, '0);
    send_word(lldec_pkg::MODE_LEARN, 10'd512, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd512, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd255, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd256, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd766, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd767, '0);
    // fill up, then learn into a full table
    send_word(lldec_pkg::MODE_LEARN, 10'd100, '0);
    send_word(lldec_pkg::MODE_LEARN, 10'd200, '0);
    send_word(lldec_pkg::MODE_LEARN, 10'd300, '0);
    send_word(lldec_pkg::MODE_LEARN, 10'd400, '0);
    send_word(lldec_pkg::MODE_LEARN, 10'd5, '0);
    send_word(lldec_pkg::MODE_CLASSIFY, '0, '0);
    // out-of-range removes are ignored; then the last and the first entry are removed
    send_word(lldec_pkg::MODE_REMOVE, '0, 4'd15);
    send_word(lldec_pkg::MODE_REMOVE, '0, 4'd8);
    send_word(lldec_pkg::MODE_REMOVE, '0, 4'd7);
    send_word(lldec_pkg::MODE_REMOVE, '0, 4'd0);
    send_word(lldec_pkg::MODE_NONE, 10'd1023, 4'd15);
    send_word(lldec_pkg::MODE_CLASSIFY, 10'd1023, '0);

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      calm <= (n >= 700 && n < 1000);
      send_random_word(n);
    end
    calm     <= 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
